### hdl/srecord_stream_loader_macros.svh
// Assertion macros for the S-record stream loader.
`ifndef SRECORD_STREAM_LOADER_MACROS_SVH
`define SRECORD_STREAM_LOADER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock outside reset.
`define SRL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srecord loader check failed");
// Next-cycle implication, checked on every clock outside reset.
`define SRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srecord loader check failed");
`else
`define SRL_ASSERT_NOW(label, clk, rst, ante, cons)
`define SRL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hdl/srl_pkg.sv
// Types, codes and decode helpers for the S-record stream loader.
package srl_pkg;

   // Parse phases
   localparam logic [2:0] PH_WAIT  = 3'd0;
   localparam logic [2:0] PH_TYPE  = 3'd1;
   localparam logic [2:0] PH_COUNT = 3'd2;
   localparam logic [2:0] PH_ADDR  = 3'd3;
   localparam logic [2:0] PH_BODY  = 3'd4;

   // Status codes
   localparam logic [2:0] ST_BUSY    = 3'd0;
   localparam logic [2:0] ST_OK      = 3'd1;
   localparam logic [2:0] ST_CSUM    = 3'd2;
   localparam logic [2:0] ST_BADADDR = 3'd3;
   localparam logic [2:0] ST_BADREC  = 3'd4;
   localparam logic [2:0] ST_END     = 3'd5;

   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] SUM_GOOD   = 8'hFF;
   localparam logic [31:0] TOP_RESET = 32'h00FF_FFFF;

   // Record kinds (the digit after 'S')
   localparam logic [3:0] KIND_HEADER = 4'd0;
   localparam logic [3:0] KIND_DATA16 = 4'd1;
   localparam logic [3:0] KIND_DATA24 = 4'd2;
   localparam logic [3:0] KIND_DATA32 = 4'd3;
   localparam logic [3:0] KIND_RSVD_A = 4'd4;
   localparam logic [3:0] KIND_COUNT  = 4'd5;
   localparam logic [3:0] KIND_RSVD_B = 4'd6;
   localparam logic [3:0] KIND_END32  = 4'd7;
   localparam logic [3:0] KIND_END24  = 4'd8;
   localparam logic [3:0] KIND_END16  = 4'd9;

   // Result item, first member in the highest bits (packed lowest field last)
   typedef struct packed {
      logic        pad;
      logic        stopped;
      logic [31:0] entry_address;
      logic        entry_valid;
      logic [2:0]  status;
      logic        record_done;
      logic [7:0]  write_data;
      logic [31:0] write_address;
      logic        write_valid;
   } rsp_type;

   // Hex digit decode: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Address length in bytes for a record kind
   function automatic logic [2:0] addr_len(input logic [3:0] kind);
      logic [2:0] r;
      r = 3'd2;
      if (kind == KIND_DATA24 || kind == KIND_END24) begin
         r = 3'd3;
      end else if (kind == KIND_DATA32 || kind == KIND_END32) begin
         r = 3'd4;
      end
      return r;
   endfunction

endpackage

### hdl/srecord_stream_loader.sv
// S-record stream loader: parses S-record text into memory writes.
//
// Usage: characters of S-record text enter one per transaction on the req_
// stream. Every accepted character produces exactly one result transaction
// on the rsp_ stream carrying a memory write (write_valid, address, data),
// record completion with checksum status, the entry address of a
// termination record and a sticky stopped flag.
// The result of a character is presented in the cycle after its
// acceptance, from a result register fed by a single pass of parse logic
// on the registered parser state.
// Throughput is one character per cycle. req_tready stays high while the
// result register is empty or being drained in the same cycle; when the
// receiver stalls, the result is held and input stalls behind it.
// Reset clears the parser to wait for 'S', empties the result register and
// sets top_address to 0x00FFFFFF. top_address is written on the csr_ channel
// (always ready), only while no character is in flight: the user must keep
// to this, the block does not enforce it. After an error or a termination
// record every further character yields stopped = 1 only, until reset.
`include "srecord_stream_loader_macros.svh"

module srecord_stream_loader #(
   parameter int ADDRESS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] write_valid, [32:1] write_address, [40:33] write_data,
   // [41] record_done, [44:42] status, [45] entry_valid,
   // [77:46] entry_address, [78] stopped, [79] zero
   output logic [79:0] rsp_tdata,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // top_address
);

   // Parser state
   logic [2:0]              parse_phase_ff, parse_phase_in;
   logic [3:0]              record_kind_ff, record_kind_in;
   logic [7:0]              bytes_left_ff, bytes_left_in;
   logic [2:0]              addr_left_ff, addr_left_in;
   logic [ADDRESS_BITS-1:0] load_address_ff, load_address_in;
   logic [7:0]              byte_sum_ff, byte_sum_in;
   logic [3:0]              upper_nibble_ff, upper_nibble_in;
   logic                    nibble_pending_ff, nibble_pending_in;
   logic                    halted_ff, halted_in;
   logic [31:0]             top_address_ff;

   // Result register
   logic                    rsp_valid_ff;
   srl_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                    req_accept;
   logic [4:0]              hex;
   logic [7:0]              byte_value;
   logic [7:0]              bytes_dec;
   logic [2:0]              addr_dec;
   logic [2:0]              kind_len;
   logic [3:0]              type_digit;
   logic [ADDRESS_BITS-1:0] shifted_address;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign hex             = srl_pkg::hex_decode(req_tdata);
   assign byte_value      = {upper_nibble_ff, hex[3:0]};
   assign bytes_dec       = bytes_left_ff - 8'd1;
   assign addr_dec        = addr_left_ff - 3'd1;
   assign kind_len        = srl_pkg::addr_len(record_kind_ff);
   assign type_digit      = req_tdata[3:0];
   assign shifted_address = {load_address_ff[ADDRESS_BITS-9:0], byte_value};

   // Parse one character
   always_comb begin
      parse_phase_in    = parse_phase_ff;
      record_kind_in    = record_kind_ff;
      bytes_left_in     = bytes_left_ff;
      addr_left_in      = addr_left_ff;
      load_address_in   = load_address_ff;
      byte_sum_in       = byte_sum_ff;
      upper_nibble_in   = upper_nibble_ff;
      nibble_pending_in = nibble_pending_ff;
      halted_in         = halted_ff;
      rsp_data_in       = '0;
      rsp_data_in.status = srl_pkg::ST_BUSY;

      if (halted_ff) begin
         halted_in = 1'b1;
      end else if (parse_phase_ff == srl_pkg::PH_WAIT) begin
         if (req_tdata == srl_pkg::CHAR_S) begin
            parse_phase_in = srl_pkg::PH_TYPE;
         end
      end else if (parse_phase_ff == srl_pkg::PH_TYPE) begin
         if (req_tdata >= srl_pkg::CHAR_ZERO && req_tdata <= srl_pkg::CHAR_NINE &&
             type_digit != srl_pkg::KIND_RSVD_A && type_digit != srl_pkg::KIND_RSVD_B) begin
            record_kind_in    = type_digit;
            parse_phase_in    = srl_pkg::PH_COUNT;
            nibble_pending_in = 1'b0;
         end else begin
            rsp_data_in.status = srl_pkg::ST_BADREC;
            halted_in          = 1'b1;
         end
      end else if (!hex[4]) begin
         rsp_data_in.status = srl_pkg::ST_BADREC;
         halted_in          = 1'b1;
      end else if (!nibble_pending_ff) begin
         upper_nibble_in   = hex[3:0];
         nibble_pending_in = 1'b1;
      end else begin
         nibble_pending_in = 1'b0;
         unique case (parse_phase_ff)
            srl_pkg::PH_COUNT: begin
               bytes_left_in   = byte_value;
               byte_sum_in     = byte_value;
               load_address_in = '0;
               if (record_kind_ff == srl_pkg::KIND_COUNT) begin
                  addr_left_in   = 3'd0;
                  parse_phase_in = (byte_value == 8'd0) ? srl_pkg::PH_WAIT
                                                        : srl_pkg::PH_BODY;
               end else begin
                  addr_left_in = kind_len;
                  if (byte_value < {5'd0, kind_len} + 8'd1) begin
                     rsp_data_in.status = srl_pkg::ST_BADREC;
                     halted_in          = 1'b1;
                  end else begin
                     parse_phase_in = srl_pkg::PH_ADDR;
                  end
               end
            end
            srl_pkg::PH_ADDR: begin
               load_address_in = shifted_address;
               byte_sum_in     = byte_sum_ff + byte_value;
               bytes_left_in   = bytes_dec;
               addr_left_in    = addr_dec;
               if (addr_dec == 3'd0) begin
                  if (record_kind_ff >= srl_pkg::KIND_END32) begin
                     rsp_data_in.entry_valid   = 1'b1;
                     rsp_data_in.entry_address = 32'(shifted_address);
                     rsp_data_in.status        = srl_pkg::ST_END;
                     halted_in                 = 1'b1;
                  end else begin
                     parse_phase_in = srl_pkg::PH_BODY;
                  end
               end
            end
            srl_pkg::PH_BODY: begin
               if (record_kind_ff == srl_pkg::KIND_COUNT) begin
                  // S5: consume count bytes silently
                  bytes_left_in = bytes_dec;
                  if (bytes_dec == 8'd0) begin
                     parse_phase_in = srl_pkg::PH_WAIT;
                  end
               end else if (bytes_left_ff <= 8'd1) begin
                  // checksum byte
                  byte_sum_in             = byte_sum_ff + byte_value;
                  rsp_data_in.record_done = 1'b1;
                  rsp_data_in.status      = (byte_sum_in == srl_pkg::SUM_GOOD)
                                            ? srl_pkg::ST_OK : srl_pkg::ST_CSUM;
                  bytes_left_in           = 8'd0;
                  parse_phase_in          = srl_pkg::PH_WAIT;
               end else begin
                  byte_sum_in   = byte_sum_ff + byte_value;
                  bytes_left_in = bytes_dec;
                  if (record_kind_ff != srl_pkg::KIND_HEADER) begin
                     if (32'(load_address_ff) > top_address_ff) begin
                        rsp_data_in.status = srl_pkg::ST_BADADDR;
                        halted_in          = 1'b1;
                     end else begin
                        rsp_data_in.write_valid   = 1'b1;
                        rsp_data_in.write_address = 32'(load_address_ff);
                        rsp_data_in.write_data    = byte_value;
                        load_address_in           = load_address_ff + ADDRESS_BITS'(1);
                     end
                  end
               end
            end
            default: begin
               parse_phase_in = parse_phase_ff;
            end
         endcase
      end
      rsp_data_in.stopped = halted_in;
   end

   // Parser state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         parse_phase_ff    <= srl_pkg::PH_WAIT;
         record_kind_ff    <= '0;
         bytes_left_ff     <= '0;
         addr_left_ff      <= '0;
         load_address_ff   <= '0;
         byte_sum_ff       <= '0;
         upper_nibble_ff   <= '0;
         nibble_pending_ff <= 1'b0;
         halted_ff         <= 1'b0;
         top_address_ff    <= srl_pkg::TOP_RESET;
      end else begin
         if (req_accept) begin
            parse_phase_ff    <= parse_phase_in;
            record_kind_ff    <= record_kind_in;
            bytes_left_ff     <= bytes_left_in;
            addr_left_ff      <= addr_left_in;
            load_address_ff   <= load_address_in;
            byte_sum_ff       <= byte_sum_in;
            upper_nibble_ff   <= upper_nibble_in;
            nibble_pending_ff <= nibble_pending_in;
            halted_ff         <= halted_in;
         end
         if (csr_valid && csr_ready) begin
            top_address_ff <= csr_data;
         end
      end
   end

   // Result register: loads on accept, empties when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Checks
   `SRL_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff)
   `SRL_ASSERT_NEXT(a_halted_result, clock, reset, req_accept && halted_ff,
      rsp_valid_ff && rsp_data_ff.stopped && !rsp_data_ff.write_valid && !rsp_data_ff.entry_valid)
   `SRL_ASSERT_NOW(a_write_busy, clock, reset, rsp_valid_ff && rsp_data_ff.write_valid,
      rsp_data_ff.status == srl_pkg::ST_BUSY && !rsp_data_ff.record_done && !rsp_data_ff.stopped)
   `SRL_ASSERT_NOW(a_entry_stops, clock, reset, rsp_valid_ff && rsp_data_ff.entry_valid,
      rsp_data_ff.stopped && rsp_data_ff.status == srl_pkg::ST_END)

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the S-record stream loader: text stream in, results predicted.
module testbench;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int HOLD_AT     = 100;
   localparam int HOLD_CYCLES = 80;

   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data   = 32'h0;

   srecord_stream_loader u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // pending characters and predicted results
   logic [7:0]       char_stream[$];
   srl_pkg::rsp_type predicted_rsp[$];
   int chars_offered      = 0;
   int chars_accepted     = 0;
   int fail_count         = 0;
   int cycle_count        = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_left          = 0;
   bit hold_done          = 1'b0;

   // parser state of the predictor
   logic [2:0]  phase_q       = srl_pkg::PH_WAIT;
   logic [3:0]  kind_q        = 4'd0;
   logic [7:0]  left_q        = 8'd0;
   logic [2:0]  alen_left_q   = 3'd0;
   logic [31:0] addr_q        = 32'd0;
   logic [7:0]  sum_q         = 8'd0;
   logic [3:0]  nib_q         = 4'd0;
   logic        nib_pending_q = 1'b0;
   logic        halted_q      = 1'b0;
   logic [31:0] top_limit     = srl_pkg::TOP_RESET;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   function automatic int addr_bytes(input logic [3:0] kind);
      if (kind == srl_pkg::KIND_DATA24 || kind == srl_pkg::KIND_END24) return 3;
      if (kind == srl_pkg::KIND_DATA32 || kind == srl_pkg::KIND_END32) return 4;
      return 2;
   endfunction

   function automatic longint unsigned max_address(input logic [3:0] kind);
      return (64'd1 << (8 * addr_bytes(kind))) - 64'd1;
   endfunction

   // one character through the parser; returns the result it causes
   function automatic srl_pkg::rsp_type parse_char(input logic [7:0] c);
      srl_pkg::rsp_type r;
      int               h;
      logic [7:0]       b;
      logic             stop_now;
      r        = '0;
      stop_now = 1'b0;
      h        = hex_value(c);
      if (halted_q) begin
         stop_now = 1'b1;
      end else if (phase_q == srl_pkg::PH_WAIT) begin
         if (c == srl_pkg::CHAR_S) phase_q = srl_pkg::PH_TYPE;
      end else if (phase_q == srl_pkg::PH_TYPE) begin
         if (c >= srl_pkg::CHAR_ZERO && c <= srl_pkg::CHAR_NINE
             && c[3:0] != srl_pkg::KIND_RSVD_A && c[3:0] != srl_pkg::KIND_RSVD_B) begin
            kind_q        = c[3:0];
            phase_q       = srl_pkg::PH_COUNT;
            nib_pending_q = 1'b0;
         end else begin
            r.status = srl_pkg::ST_BADREC;
            stop_now = 1'b1;
         end
      end else if (h < 0) begin
         r.status = srl_pkg::ST_BADREC;
         stop_now = 1'b1;
      end else if (!nib_pending_q) begin
         nib_q         = h[3:0];
         nib_pending_q = 1'b1;
      end else begin
         b             = {nib_q, h[3:0]};
         nib_pending_q = 1'b0;
         if (phase_q == srl_pkg::PH_COUNT) begin
            left_q = b;
            sum_q  = b;
            addr_q = 32'd0;
            if (kind_q == srl_pkg::KIND_COUNT) begin
               alen_left_q = 3'd0;
               phase_q     = (b == 8'd0) ? srl_pkg::PH_WAIT : srl_pkg::PH_BODY;
            end else begin
               alen_left_q = 3'(addr_bytes(kind_q));
               if (int'(b) < int'(alen_left_q) + 1) begin
                  r.status = srl_pkg::ST_BADREC;
                  stop_now = 1'b1;
               end else begin
                  phase_q = srl_pkg::PH_ADDR;
               end
            end
         end else if (phase_q == srl_pkg::PH_ADDR) begin
            addr_q      = {addr_q[23:0], b};
            sum_q       = sum_q + b;
            left_q      = left_q - 8'd1;
            alen_left_q = alen_left_q - 3'd1;
            if (alen_left_q == 3'd0) begin
               if (kind_q >= srl_pkg::KIND_END32) begin
                  r.entry_valid   = 1'b1;
                  r.entry_address = addr_q;
                  r.status        = srl_pkg::ST_END;
                  stop_now        = 1'b1;
               end else begin
                  phase_q = srl_pkg::PH_BODY;
               end
            end
         end else if (kind_q == srl_pkg::KIND_COUNT) begin
            // S5 body is only counted off
            left_q = left_q - 8'd1;
            if (left_q == 8'd0) phase_q = srl_pkg::PH_WAIT;
         end else if (left_q <= 8'd1) begin
            sum_q         = sum_q + b;
            r.record_done = 1'b1;
            r.status      = (sum_q == srl_pkg::SUM_GOOD) ? srl_pkg::ST_OK : srl_pkg::ST_CSUM;
            left_q        = 8'd0;
            phase_q       = srl_pkg::PH_WAIT;
         end else begin
            sum_q  = sum_q + b;
            left_q = left_q - 8'd1;
            if (kind_q != srl_pkg::KIND_HEADER) begin
               if (addr_q > top_limit) begin
                  r.status = srl_pkg::ST_BADADDR;
                  stop_now = 1'b1;
               end else begin
                  r.write_valid   = 1'b1;
                  r.write_address = addr_q;
                  r.write_data    = b;
                  addr_q          = addr_q + 32'd1;
               end
            end
         end
      end
      if (stop_now) halted_q = 1'b1;
      r.stopped = halted_q;
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
      if (v < 4'd10) return 8'(srl_pkg::CHAR_ZERO + v);
      return 8'((lower ? 8'h61 : 8'h41) + v - 10);
   endfunction

   // byte as two hex digits, case chosen at random
   task automatic push_hex(input logic [7:0] v);
      bit lower;
      lower = 1'($urandom_range(0, 1));
      char_stream.push_back(hex_char(v[7:4], lower));
      char_stream.push_back(hex_char(v[3:0], lower));
   endtask

   task automatic add_record(input logic [3:0] kind, input logic [31:0] addr, input int n,
                             input bit bad_sum);
      int         alen;
      int         i;
      logic [7:0] sum;
      logic [7:0] v;
      logic [7:0] count;
      alen  = (kind == srl_pkg::KIND_COUNT) ? 0 : addr_bytes(kind);
      count = (kind == srl_pkg::KIND_COUNT) ? 8'(n) : 8'(alen + n + 1);
      char_stream.push_back(srl_pkg::CHAR_S);
      char_stream.push_back(8'(srl_pkg::CHAR_ZERO + kind));
      push_hex(count);
      sum = count;
      for (i = alen - 1; i >= 0; i--) begin
         v = 8'(addr >> (8 * i));
         push_hex(v);
         sum = sum + v;
      end
      for (i = 0; i < n; i++) begin
         v = 8'($urandom_range(0, 255));
         push_hex(v);
         sum = sum + v;
      end
      if (kind != srl_pkg::KIND_COUNT) begin
         v = ~sum;
         if (bad_sum) v = v ^ 8'($urandom_range(1, 255));
         push_hex(v);
      end
   endtask

   // line ends and junk between records, never an 'S'
   task automatic add_noise(input int n);
      int         i;
      logic [7:0] v;
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 2))
            0: v = CHAR_CR;
            1: v = CHAR_LF;
            default: begin
               v = 8'($urandom_range(0, 255));
               if (v == srl_pkg::CHAR_S) v = CHAR_LF;
            end
         endcase
         char_stream.push_back(v);
      end
   endtask

   // record that stays inside the current top address, at random with a bad checksum
   task automatic add_random_record;
      logic [3:0]      kind;
      int              n;
      longint unsigned lim;
      longint unsigned a;
      case ($urandom_range(0, 9))
         0:       kind = srl_pkg::KIND_HEADER;
         1, 2, 3: kind = srl_pkg::KIND_DATA16;
         4, 5:    kind = srl_pkg::KIND_DATA24;
         6, 7:    kind = srl_pkg::KIND_DATA32;
         default: kind = srl_pkg::KIND_COUNT;
      endcase
      n   = int'(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8));
      lim = max_address(kind);
      a   = {$urandom, $urandom} % (lim + 64'd1);
      if (kind != srl_pkg::KIND_HEADER && kind != srl_pkg::KIND_COUNT && n != 0) begin
         if (64'(top_limit) < lim) lim = 64'(top_limit);
         if (64'(n) > lim + 64'd1) n = int'(lim + 64'd1);
         if ($urandom_range(0, 3) == 0) a = lim - 64'(n - 1);
         else a = {$urandom, $urandom} % (lim - 64'(n - 1) + 64'd1);
      end
      add_record(kind, a[31:0], n, $urandom_range(0, 9) == 0);
      add_noise(int'($urandom_range(0, 3)));
   endtask

   task automatic fill_random(input int chars);
      int target;
      target = char_stream.size() + chars;
      while (char_stream.size() < target) add_random_record();
   endtask

   // all characters taken and all results answered
   task automatic wait_drained;
      do @(negedge clock);
      while (char_stream.size() != 0 || chars_accepted != chars_offered
             || predicted_rsp.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_top(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // character driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && chars_accepted != chars_offered) begin
         // transaction still waiting, hold it
      end else if (char_stream.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
         req_tvalid <= 1'b1;
         req_tdata  <= char_stream.pop_front();
         chars_offered++;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result receiver, with one long hold-off to back up the input
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && chars_accepted >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // monitor: check results, track config writes, predict accepted characters
   always @(posedge clock) begin : monitor
      srl_pkg::rsp_type got_rsp;
      srl_pkg::rsp_type want_rsp;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_tdata;
            if (predicted_rsp.size() == 0) begin
               $error("result transaction with no character outstanding");
               fail_count++;
            end else begin
               want_rsp = predicted_rsp.pop_front();
               check_field("write_valid", 32'(want_rsp.write_valid),
                           32'(got_rsp.write_valid));
               check_field("write_address", want_rsp.write_address, got_rsp.write_address);
               check_field("write_data", 32'(want_rsp.write_data), 32'(got_rsp.write_data));
               check_field("record_done", 32'(want_rsp.record_done),
                           32'(got_rsp.record_done));
               check_field("status", 32'(want_rsp.status), 32'(got_rsp.status));
               check_field("entry_valid", 32'(want_rsp.entry_valid),
                           32'(got_rsp.entry_valid));
               check_field("entry_address", want_rsp.entry_address, got_rsp.entry_address);
               check_field("stopped", 32'(want_rsp.stopped), 32'(got_rsp.stopped));
            end
         end
         if (csr_valid && csr_ready) top_limit = csr_data;
         if (req_tvalid && req_tready) begin
            predicted_rsp.push_back(parse_char(req_tdata));
            chars_accepted++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [7:0] v;
      logic [3:0] kind;
      int         i;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: junk before the records, header, data and count records, boundaries, bad checksum
      char_stream.push_back(8'h00);
      char_stream.push_back(8'hFF);
      char_stream.push_back(8'h80);
      char_stream.push_back(CHAR_CR);
      char_stream.push_back(CHAR_LF);
      char_stream.push_back("s");
      add_record(srl_pkg::KIND_HEADER, 32'h0, 3, 1'b0);
      add_record(srl_pkg::KIND_DATA16, 32'h0000, 2, 1'b0);
      add_record(srl_pkg::KIND_DATA16, 32'hFFFF, 1, 1'b0);
      add_record(srl_pkg::KIND_DATA24, srl_pkg::TOP_RESET, 1, 1'b0);
      add_record(srl_pkg::KIND_DATA32, 32'h00FF_FFFE, 2, 1'b0);
      add_record(srl_pkg::KIND_DATA16, 32'h1234, 0, 1'b0);
      add_record(srl_pkg::KIND_COUNT, 32'h0, 0, 1'b0);
      add_record(srl_pkg::KIND_COUNT, 32'h0, 3, 1'b0);
      add_record(srl_pkg::KIND_DATA24, 32'h0000_8000, 2, 1'b1);
      fill_random(200);
      wait_drained();

      // full address range; load address wraps past the top
      write_top(32'hFFFF_FFFF);
      sender_idle_pct = 54;
      add_record(srl_pkg::KIND_DATA32, 32'hFFFF_FFFE, 4, 1'b0);
      add_record(srl_pkg::KIND_DATA32, 32'hFFFF_FFFF, 1, 1'b0);
      fill_random(220);
      wait_drained();

      // only address zero writable
      write_top(32'h0);
      sender_idle_pct    = 0;
      receiver_stall_pct = 54;
      add_record(srl_pkg::KIND_DATA16, 32'h0, 1, 1'b0);
      fill_random(220);
      wait_drained();

      write_top(32'($urandom_range(0, 32'h00FF_FFFF)));
      sender_idle_pct    = 31;
      receiver_stall_pct = 31;
      fill_random(200);

      // one load-ending case, then characters that must be ignored
      case ($urandom_range(0, 4))
         0: begin
            case ($urandom_range(0, 2))
               0:       kind = srl_pkg::KIND_END32;
               1:       kind = srl_pkg::KIND_END24;
               default: kind = srl_pkg::KIND_END16;
            endcase
            add_record(kind, $urandom, 0, 1'b0);
         end
         1: begin
            // unknown record type
            char_stream.push_back(srl_pkg::CHAR_S);
            case ($urandom_range(0, 2))
               0:       v = 8'(srl_pkg::CHAR_ZERO + srl_pkg::KIND_RSVD_A);
               1:       v = 8'(srl_pkg::CHAR_ZERO + srl_pkg::KIND_RSVD_B);
               default: begin
                  v = 8'($urandom_range(0, 255));
                  if (v >= srl_pkg::CHAR_ZERO && v <= srl_pkg::CHAR_NINE) v = v ^ 8'h40;
               end
            endcase
            char_stream.push_back(v);
         end
         2: begin
            // non-hex character inside the address
            char_stream.push_back(srl_pkg::CHAR_S);
            char_stream.push_back(8'(srl_pkg::CHAR_ZERO + srl_pkg::KIND_DATA16));
            push_hex(8'h05);
            push_hex(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1) char_stream.push_back("7");
            case ($urandom_range(0, 3))
               0:       v = CHAR_CR;
               1:       v = CHAR_LF;
               2:       v = "G";
               default: begin
                  v = 8'($urandom_range(0, 255));
                  if (hex_value(v) >= 0) v = "g";
               end
            endcase
            char_stream.push_back(v);
         end
         3: begin
            // count too small for the address
            case ($urandom_range(0, 5))
               0:       kind = srl_pkg::KIND_DATA16;
               1:       kind = srl_pkg::KIND_DATA24;
               2:       kind = srl_pkg::KIND_DATA32;
               3:       kind = srl_pkg::KIND_END32;
               4:       kind = srl_pkg::KIND_END24;
               default: kind = srl_pkg::KIND_END16;
            endcase
            char_stream.push_back(srl_pkg::CHAR_S);
            char_stream.push_back(8'(srl_pkg::CHAR_ZERO + kind));
            push_hex(8'($urandom_range(0, addr_bytes(kind))));
         end
         default: begin
            // second data byte lands above the top address
            add_record(srl_pkg::KIND_DATA32, top_limit, 3, 1'b0);
         end
      endcase
      for (i = 0; i < 16; i++) char_stream.push_back(8'($urandom_range(0, 255)));
      add_record(srl_pkg::KIND_DATA16, 32'h0, 1, 1'b0);
      wait_drained();

      if (fail_count == 0 && predicted_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
